FILE: hw/rtl/sprite_frame_sequencer_top_assert.svh
// assertion macros for the sprite frame sequencer
// included by the top level, no other dependencies
`ifndef SPRITE_FRAME_SEQUENCER_TOP_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfs assertion failed");
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfs assertion failed");
`else
`define SFS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/sfs_pkg.sv
// types and constants of the sprite frame sequencer
// no dependencies
package sfs_pkg;
	localparam int unsigned MAX_FRAMES_DEF   = 256;
	localparam int unsigned MAX_TRIGGERS_DEF = 16;
	localparam int unsigned LEN_W            = 17;
	localparam logic [24:0] ZERO_LEN_Q8      = 25'd4268;
	localparam logic [15:0] SPEED_ONE        = 16'd256;

	typedef enum logic [2:0] {
		ACT_TICK      = 3'd0,
		ACT_LOAD_LEN  = 3'd1,
		ACT_LOAD_TRIG = 3'd2,
		ACT_PLAY      = 3'd3,
		ACT_PAUSE     = 3'd4,
		ACT_STOP      = 3'd5,
		ACT_GOTO      = 3'd6,
		ACT_RESET     = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		REG_FRAMES     = 3'd0,
		REG_LOOP_EN    = 3'd1,
		REG_LOOP_FIRST = 3'd2,
		REG_SPEED      = 3'd3,
		REG_EVENTS     = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_LEN,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_FLUSH
	} state_t;
endpackage

FILE: hw/rtl/sfs_if.sv
// channel interfaces of the sprite frame sequencer
// no dependencies
interface sfs_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [23:0] elapsed_q8;
	logic [7:0]  slot_index;
	logic [15:0] duration_ms;
	logic [15:0] delay_ms;
	logic [7:0]  trigger_frame;
	modport source (output valid, action, elapsed_q8, slot_index, duration_ms, delay_ms,
		trigger_frame, input ready);
	modport sink (input valid, action, elapsed_q8, slot_index, duration_ms, delay_ms,
		trigger_frame, output ready);
endinterface

interface sfs_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  shown_frame;
	logic [7:0]  start_frame;
	logic [7:0]  advances;
	logic        ended_now;
	logic        running;
	logic        done_res;
	logic [15:0] loops_done;
	logic [3:0]  trigger_slot;
	logic        last;
	modport source (output valid, kind, shown_frame, start_frame, advances, ended_now, running,
		done_res, loops_done, trigger_slot, last, input ready);
	modport sink (input valid, kind, shown_frame, start_frame, advances, ended_now, running,
		done_res, loops_done, trigger_slot, last, output ready);
endinterface

interface sfs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/sfs_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module sfs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/sprite_frame_sequencer_top.sv
// sprite frame sequencer, top level
// depends on sfs_pkg, sfs_if, sfs_ram and sprite_frame_sequencer_top_assert.svh
//
// item: commands (tick, load frame, load trigger, play, pause, stop, goto, reset)
// result: one transfer per fired trigger, then one status transfer per item; last marks
// the final transfer of an item
// cfg: register writes, always ready, index selects the register
// one item is worked on at a time; item.ready is high only between items
// control items go straight to their status transfer
// a running tick adds the scaled elapsed time to the timer, then makes one read
// of the frame length ram per frame advance and one read and compare per
// trigger entry scanned; one tick can advance up to 2^24 - 1 frames
// an output register holds the latest result; when result.ready is low the
// sequencer waits only when it must push a further result, so a new item can
// be taken while the last result of the previous one still waits
// reset clears the control state and the registers; both tables are undefined
// until loaded, and need no clearing pass
`include "sprite_frame_sequencer_top_assert.svh"
module sprite_frame_sequencer_top #(
	parameter int unsigned MAX_FRAMES   = sfs_pkg::MAX_FRAMES_DEF,
	parameter int unsigned MAX_TRIGGERS = sfs_pkg::MAX_TRIGGERS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sfs_item_if.sink     item,
	sfs_result_if.source result,
	sfs_cfg_if.sink      cfg
);
	localparam int unsigned FA_W = $clog2(MAX_FRAMES);
	localparam int unsigned TA_W = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;

	sfs_pkg::state_t state_q, state_d;

	logic [8:0]  frames_in_use_q;
	logic        loop_enable_q;
	logic [7:0]  loop_first_q;
	logic [15:0] speed_q;
	logic [4:0]  events_in_use_q;

	logic [7:0]  frame_now_q;
	logic [31:0] timer_q;
	logic        playing_q, paused_q, finished_q;
	logic [15:0] loops_q;
	logic [6:0]  base_q;
	logic [6:0]  idx_q;

	logic [39:0] prod_s1;
	logic [7:0]  start_q, adv_q;
	logic        ended_q;
	logic        pend_kind_q;
	logic [3:0]  pend_slot_q;

	logic        out_valid_q, out_kind_q, out_ended_q, out_running_q, out_done_q, out_last_q;
	logic [7:0]  out_shown_q, out_start_q, out_adv_q;
	logic [15:0] out_loops_q;
	logic [3:0]  out_slot_q;

	logic                         accept, out_free, push, push_last, active;
	logic [12:0]                  count13, next13, frame13;
	logic [7:0]                   count_m1, new_frame, goto_frame;
	logic [6:0]                   nev;
	logic [15:0]                  spd;
	logic [32:0]                  sum33;
	logic [31:0]                  len32;
	logic [sfs_pkg::LEN_W-1:0]    len_rd;
	logic [7:0]                   trig_rd;
	logic                         take, at_end, stop_now, match;
	logic [11:0]                  frd_ext, fwr_ext;
	logic [FA_W-1:0]              frd_addr;
	logic                         fwe, twe;

	assign accept   = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;
	assign item.ready = (state_q == sfs_pkg::ST_IDLE);
	assign cfg.ready  = 1'b1;

	assign frame13 = {5'b0, frame_now_q};
	assign next13  = frame13 + 13'd1;
	assign count13 = ({4'b0, frames_in_use_q} > 13'(MAX_FRAMES)) ? 13'(MAX_FRAMES)
		: {4'b0, frames_in_use_q};
	assign count_m1 = 8'(count13 - 13'd1);
	assign nev = ({2'b0, events_in_use_q} > 7'(MAX_TRIGGERS)) ? 7'(MAX_TRIGGERS)
		: {2'b0, events_in_use_q};
	assign active = playing_q && !paused_q && (count13 != 13'd0);
	assign spd = (speed_q == 16'd0) ? sfs_pkg::SPEED_ONE : speed_q;
	assign sum33 = {1'b0, timer_q} + {1'b0, prod_s1[39:8]};
	assign goto_frame = (count13 == 13'd0) ? 8'd0
		: (({5'b0, item.slot_index} >= count13) ? count_m1 : item.slot_index);

	assign len32 = (len_rd == '0) ? {7'b0, sfs_pkg::ZERO_LEN_Q8}
		: {7'b0, len_rd, 8'b0};
	assign take     = timer_q >= len32;
	assign at_end   = next13 >= count13;
	assign new_frame = at_end ? ((({5'b0, loop_first_q}) < count13) ? loop_first_q : 8'd0)
		: next13[7:0];
	assign stop_now = at_end && !loop_enable_q;
	assign match    = trig_rd == frame_now_q;

	// frame length ram: next frame is read while advancing
	assign frd_ext = (state_q == sfs_pkg::ST_LEN && take && !stop_now)
		? {4'b0, new_frame} : {4'b0, frame_now_q};
	assign frd_addr = frd_ext[FA_W-1:0];
	assign fwr_ext  = {4'b0, item.slot_index};
	assign fwe = accept && (sfs_pkg::action_t'(item.action) == sfs_pkg::ACT_LOAD_LEN)
		&& ({5'b0, item.slot_index} < 13'(MAX_FRAMES));
	assign twe = accept && (sfs_pkg::action_t'(item.action) == sfs_pkg::ACT_LOAD_TRIG)
		&& ({5'b0, item.slot_index} < 13'(MAX_TRIGGERS));

	sfs_ram #(.WIDTH(sfs_pkg::LEN_W), .DEPTH(MAX_FRAMES)) u_len_ram (
		.clk   (clk),
		.we    (fwe),
		.waddr (fwr_ext[FA_W-1:0]),
		.wdata (17'(item.duration_ms) + 17'(item.delay_ms)),
		.raddr (frd_addr),
		.rdata (len_rd)
	);

	sfs_ram #(.WIDTH(8), .DEPTH(MAX_TRIGGERS)) u_trig_ram (
		.clk   (clk),
		.we    (twe),
		.waddr (item.slot_index[TA_W-1:0]),
		.wdata (item.trigger_frame),
		.raddr (idx_q[TA_W-1:0]),
		.rdata (trig_rd)
	);

	always_comb begin
		state_d   = state_q;
		push      = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			sfs_pkg::ST_IDLE: begin
				if (accept) begin
					if (sfs_pkg::action_t'(item.action) == sfs_pkg::ACT_TICK && active) begin
						state_d = sfs_pkg::ST_ADD;
					end else begin
						state_d = sfs_pkg::ST_FLUSH;
					end
				end
			end
			sfs_pkg::ST_ADD: state_d = sfs_pkg::ST_LEN;
			sfs_pkg::ST_LEN: begin
				if (!take || stop_now) begin
					state_d = sfs_pkg::ST_SCAN_RD;
				end
			end
			sfs_pkg::ST_SCAN_RD: begin
				state_d = (idx_q >= nev) ? sfs_pkg::ST_FLUSH : sfs_pkg::ST_SCAN_CMP;
			end
			sfs_pkg::ST_SCAN_CMP: begin
				if (!match) begin
					state_d = sfs_pkg::ST_SCAN_RD;
				end else if (out_free) begin
					push    = 1'b1;
					state_d = sfs_pkg::ST_SCAN_RD;
				end
			end
			sfs_pkg::ST_FLUSH: begin
				if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_d   = sfs_pkg::ST_IDLE;
				end
			end
			default: state_d = sfs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= '0;
			loop_enable_q   <= 1'b0;
			loop_first_q    <= '0;
			speed_q         <= sfs_pkg::SPEED_ONE;
			events_in_use_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (sfs_pkg::reg_index_t'(cfg.index))
				sfs_pkg::REG_FRAMES:     frames_in_use_q <= cfg.data[8:0];
				sfs_pkg::REG_LOOP_EN:    loop_enable_q   <= cfg.data[0];
				sfs_pkg::REG_LOOP_FIRST: loop_first_q    <= cfg.data[7:0];
				sfs_pkg::REG_SPEED:      speed_q         <= cfg.data;
				sfs_pkg::REG_EVENTS:     events_in_use_q <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_now_q <= '0;
			timer_q     <= '0;
			playing_q   <= 1'b0;
			paused_q    <= 1'b0;
			finished_q  <= 1'b0;
			loops_q     <= '0;
			base_q      <= '0;
			idx_q       <= '0;
			adv_q       <= '0;
			ended_q     <= 1'b0;
			pend_kind_q <= 1'b0;
			pend_slot_q <= '0;
		end else begin
			unique case (state_q)
				sfs_pkg::ST_IDLE: begin
					if (accept) begin
						adv_q       <= '0;
						ended_q     <= 1'b0;
						pend_kind_q <= 1'b0;
						pend_slot_q <= '0;
						unique case (sfs_pkg::action_t'(item.action))
							sfs_pkg::ACT_PLAY: begin
								playing_q  <= 1'b1;
								paused_q   <= 1'b0;
								finished_q <= 1'b0;
							end
							sfs_pkg::ACT_PAUSE: paused_q <= 1'b1;
							sfs_pkg::ACT_STOP, sfs_pkg::ACT_RESET: begin
								if (sfs_pkg::action_t'(item.action) == sfs_pkg::ACT_STOP) begin
									playing_q <= 1'b0;
									paused_q  <= 1'b0;
								end
								frame_now_q <= '0;
								timer_q     <= '0;
								finished_q  <= 1'b0;
								loops_q     <= '0;
								base_q      <= '0;
							end
							sfs_pkg::ACT_GOTO: begin
								frame_now_q <= goto_frame;
								timer_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				sfs_pkg::ST_ADD: begin
					timer_q <= sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
				end
				sfs_pkg::ST_LEN: begin
					if (take) begin
						timer_q <= timer_q - len32;
						if (stop_now) begin
							finished_q  <= 1'b1;
							playing_q   <= 1'b0;
							frame_now_q <= count_m1;
							ended_q     <= 1'b1;
						end else begin
							frame_now_q <= new_frame;
							if (at_end && loops_q != 16'hFFFF) begin
								loops_q <= loops_q + 16'd1;
							end
							if (new_frame != frame_now_q && adv_q != 8'hFF) begin
								adv_q <= adv_q + 8'd1;
							end
						end
					end
					idx_q <= base_q;
				end
				sfs_pkg::ST_SCAN_CMP: begin
					if (!match) begin
						idx_q <= idx_q + 7'd1;
					end else if (out_free) begin
						pend_kind_q <= 1'b1;
						pend_slot_q <= idx_q[3:0];
						base_q      <= idx_q + 7'd1;
						idx_q       <= idx_q + 7'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// item payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= frame_now_q;
			prod_s1 <= 40'(item.elapsed_q8) * 40'(spd);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_kind_q    <= pend_kind_q;
			out_shown_q   <= frame_now_q;
			out_start_q   <= start_q;
			out_adv_q     <= adv_q;
			out_ended_q   <= ended_q;
			out_running_q <= playing_q && !paused_q;
			out_done_q    <= finished_q;
			out_loops_q   <= loops_q;
			out_slot_q    <= pend_slot_q;
			out_last_q    <= push_last;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.kind         = out_kind_q;
	assign result.shown_frame  = out_shown_q;
	assign result.start_frame  = out_start_q;
	assign result.advances     = out_adv_q;
	assign result.ended_now    = out_ended_q;
	assign result.running      = out_running_q;
	assign result.done_res     = out_done_q;
	assign result.loops_done   = out_loops_q;
	assign result.trigger_slot = out_slot_q;
	assign result.last         = out_last_q;

	`SFS_ASSERT_IMPL(a_frame_in_table, clk, arst_n, 1'b1, {5'b0, frame_now_q} < 13'(MAX_FRAMES))
	`SFS_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != sfs_pkg::ST_IDLE)
	`SFS_ASSERT_IMPL(a_ended_stopped, clk, arst_n, ended_q, !playing_q && finished_q)
	`SFS_ASSERT_IMPL(a_scan_above_fired, clk, arst_n, state_q == sfs_pkg::ST_SCAN_CMP, idx_q >= base_q)
endmodule
